/* hdl/dtbp_pkg.sv */
// dtbp_pkg: shared types and constants for the devicetree blob token parser.
// Used by the event channel interface and by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dtbp_pkg;

    localparam logic [31:0] FDT_MAGIC      = 32'hd00dfeed;
    localparam logic [31:0] MIN_STRUCT_OFF = 32'd40;
    localparam logic [31:0] WORD_BYTES     = 32'd4;

    // header byte positions
    localparam logic [31:0] HDR_MAGIC_LAST   = 32'd3;
    localparam logic [31:0] HDR_STRUCT_LAST  = 32'd11;
    localparam logic [31:0] HDR_STRINGS_LAST = 32'd15;

    // byte positions relative to the token word
    localparam logic [31:0] REL_TOKEN_LAST   = 32'd3;
    localparam logic [31:0] REL_LENGTH_LAST  = 32'd7;
    localparam logic [31:0] REL_NAMEOFF_LAST = 32'd11;

    // structure block token codes
    localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
    localparam logic [31:0] TOK_END_NODE   = 32'd2;
    localparam logic [31:0] TOK_PROP       = 32'd3;
    localparam logic [31:0] TOK_NOP        = 32'd4;
    localparam logic [31:0] TOK_END        = 32'd9;

    typedef enum logic [2:0] {
        EV_BEGIN_NODE = 3'd0,
        EV_END_NODE   = 3'd1,
        EV_PROP       = 3'd2,
        EV_NOP        = 3'd3,
        EV_END        = 3'd4,
        EV_BAD_HEADER = 3'd5,
        EV_BAD_TOKEN  = 3'd6
    } event_kind_t;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_WAIT     = 3'd1,
        PH_TOKEN    = 3'd2,
        PH_NAME     = 3'd3,
        PH_PROPHEAD = 3'd4,
        PH_DATA     = 3'd5,
        PH_ALIGN    = 3'd6,
        PH_DONE     = 3'd7
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] byte_pos;
        logic [31:0] word_shift;
        logic [31:0] struct_start;
        logic [31:0] strings_start;
        logic [31:0] token_off;
        logic [31:0] prop_len;
        logic [31:0] skip_rem;
    } parse_state_t;

    typedef struct packed {
        event_kind_t kind;
        logic [31:0] token_offset;
        logic [31:0] name_offset;
        logic [31:0] data_offset;
        logic [31:0] data_length;
        logic [31:0] token_value;
    } event_t;

endpackage

`default_nettype wire

/* hdl/dtbp_in_if.sv */
// dtbp_in_if: valid/ready channel carrying one blob byte per transaction.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface dtbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] blob_byte;

    modport source (output valid, output blob_byte, input ready);
    modport sink   (input valid, input blob_byte, output ready);
endinterface

`default_nettype wire

/* hdl/dtbp_out_if.sv */
// dtbp_out_if: valid/ready channel carrying one parser event per transaction.
// Depends on dtbp_pkg for the event kind type.
`timescale 1ns / 1ps
`default_nettype none

interface dtbp_out_if
    import dtbp_pkg::*;
;
    logic        valid;
    logic        ready;
    event_kind_t event_kind;
    logic [31:0] token_offset;
    logic [31:0] name_offset;
    logic [31:0] data_offset;
    logic [31:0] data_length;
    logic [31:0] token_value;

    modport source (output valid, output event_kind, output token_offset,
                    output name_offset, output data_offset, output data_length,
                    output token_value, input ready);
    modport sink   (input valid, input event_kind, input token_offset,
                    input name_offset, input data_offset, input data_length,
                    input token_value, output ready);
endinterface

`default_nettype wire

/* hdl/dtbp_step.sv */
// dtbp_step: next-state and event logic for one accepted blob byte.
// Depends on dtbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtbp_step
    import dtbp_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   blob_byte,
    output parse_state_t nxt,
    output logic         ev_valid,
    output event_t       ev
);

    always_comb
    begin
        logic        take;
        phase_t      ph;
        logic [31:0] pos;
        logic [31:0] tok;
        logic [31:0] shift;
        logic [31:0] rel;
        logic [31:0] skip_dec;

        nxt      = cur;
        ev_valid = 1'b0;
        ev       = '0;
        pos      = cur.byte_pos;
        ph       = cur.phase;
        tok      = cur.token_off;
        take     = 1'b1;
        shift    = {cur.word_shift[23:0], blob_byte};
        skip_dec = cur.skip_rem - 32'd1;

        // waiting phases hand over to token decode on the right byte
        if (ph == PH_WAIT)
        begin
            if (pos != cur.struct_start)
                take = 1'b0;
            else
            begin
                ph  = PH_TOKEN;
                tok = pos;
            end
        end
        else if (ph == PH_ALIGN)
        begin
            if (pos[1:0] != 2'd0)
                take = 1'b0;
            else
            begin
                ph  = PH_TOKEN;
                tok = pos;
            end
        end
        rel = pos - tok;

        if (cur.phase != PH_DONE)
        begin
            nxt.byte_pos = pos + 32'd1;
            if (take)
            begin
                nxt.phase      = ph;
                nxt.token_off  = tok;
                nxt.word_shift = shift;
                unique case (ph)
                    PH_HEADER:
                    begin
                        if (pos == HDR_MAGIC_LAST && shift != FDT_MAGIC)
                        begin
                            ev_valid  = 1'b1;
                            ev.kind   = EV_BAD_HEADER;
                            nxt.phase = PH_DONE;
                        end
                        else if (pos == HDR_STRUCT_LAST)
                        begin
                            nxt.struct_start = shift;
                            if (shift < MIN_STRUCT_OFF)
                            begin
                                ev_valid  = 1'b1;
                                ev.kind   = EV_BAD_HEADER;
                                nxt.phase = PH_DONE;
                            end
                        end
                        else if (pos == HDR_STRINGS_LAST)
                        begin
                            nxt.strings_start = shift;
                            nxt.phase         = PH_WAIT;
                        end
                    end
                    PH_TOKEN:
                    begin
                        if (rel == REL_TOKEN_LAST)
                        begin
                            ev.token_offset = tok;
                            ev.token_value  = shift;
                            case (shift)
                                TOK_BEGIN_NODE:
                                begin
                                    ev_valid       = 1'b1;
                                    ev.kind        = EV_BEGIN_NODE;
                                    ev.name_offset = tok + WORD_BYTES;
                                    nxt.phase      = PH_NAME;
                                end
                                TOK_END_NODE:
                                begin
                                    ev_valid  = 1'b1;
                                    ev.kind   = EV_END_NODE;
                                    nxt.phase = PH_ALIGN;
                                end
                                TOK_PROP:
                                begin
                                    nxt.phase = PH_PROPHEAD;
                                end
                                TOK_NOP:
                                begin
                                    ev_valid  = 1'b1;
                                    ev.kind   = EV_NOP;
                                    nxt.phase = PH_ALIGN;
                                end
                                TOK_END:
                                begin
                                    ev_valid  = 1'b1;
                                    ev.kind   = EV_END;
                                    nxt.phase = PH_DONE;
                                end
                                default:
                                begin
                                    ev_valid  = 1'b1;
                                    ev.kind   = EV_BAD_TOKEN;
                                    nxt.phase = PH_DONE;
                                end
                            endcase
                        end
                    end
                    PH_NAME:
                    begin
                        if (blob_byte == 8'd0)
                            nxt.phase = PH_ALIGN;
                    end
                    PH_PROPHEAD:
                    begin
                        if (rel == REL_LENGTH_LAST)
                            nxt.prop_len = shift;
                        else if (rel == REL_NAMEOFF_LAST)
                        begin
                            ev_valid        = 1'b1;
                            ev.kind         = EV_PROP;
                            ev.token_offset = tok;
                            ev.name_offset  = cur.strings_start + shift;
                            ev.data_offset  = pos + 32'd1;
                            ev.data_length  = cur.prop_len;
                            ev.token_value  = TOK_PROP;
                            nxt.skip_rem    = cur.prop_len;
                            nxt.phase = (cur.prop_len == 32'd0) ? PH_ALIGN : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        nxt.skip_rem = skip_dec;
                        if (skip_dec == 32'd0)
                            nxt.phase = PH_ALIGN;
                    end
                    default:
                    begin
                        nxt.phase = PH_DONE;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/dtbp_out_reg.sv */
// dtbp_out_reg: output register plus one skid entry for the event channel.
// Depends on dtbp_pkg and dtbp_out_if.
`timescale 1ns / 1ps
`default_nettype none

module dtbp_out_reg
    import dtbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  event_t     push_data,
    output logic       space,
    dtbp_out_if.source events
);

    logic   main_valid_reg;
    logic   skid_valid_reg;
    event_t main_reg;
    event_t skid_reg;
    logic   pop;

    assign pop   = main_valid_reg && events.ready;
    assign space = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                main_valid_reg <= push;
        end
        else if (push)
        begin
            if (main_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (push)
                main_reg <= push_data;
        end
        else if (push)
        begin
            if (main_valid_reg)
                skid_reg <= push_data;
            else
                main_reg <= push_data;
        end
    end

    assign events.valid        = main_valid_reg;
    assign events.event_kind   = main_reg.kind;
    assign events.token_offset = main_reg.token_offset;
    assign events.name_offset  = main_reg.name_offset;
    assign events.data_offset  = main_reg.data_offset;
    assign events.data_length  = main_reg.data_length;
    assign events.token_value  = main_reg.token_value;

    skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without a head entry");

    skid_drains_to_main: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && skid_valid_reg) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry lost on pop");

    stall_keeps_head: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && !events.ready) |=> main_valid_reg)
        else $error("head entry dropped while stalled");

endmodule

`default_nettype wire

/* hdl/devicetree_blob_token_parser.sv */
// devicetree_blob_token_parser: top level, walks a flattened devicetree blob.
// Depends on dtbp_pkg, dtbp_in_if, dtbp_out_if, dtbp_step, dtbp_out_reg.
// Throughput: one blob byte per cycle, every cycle, while the event queue has room.
// An event is pushed into the event queue on the byte that completes its token.
// Events sit in an output register backed by one skid entry; input stalls only
// when both are full. Reset (rst_n low, async) returns to the header phase at
// offset zero and empties both event entries.
`timescale 1ns / 1ps
`default_nettype none

module devicetree_blob_token_parser
    import dtbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dtbp_in_if.sink    blob,
    dtbp_out_if.source events
);

    // Parser state: phase, byte counter, header offsets and skip counters.
    parse_state_t state_reg;
    parse_state_t state_next;

    logic   in_fire;
    logic   ev_valid;
    event_t ev;
    logic   space;

    // Ready is registered inside the output stage: only a full skid entry
    // holds the blob stream back.
    assign blob.ready = space;
    assign in_fire    = blob.valid && space;

    // One byte's worth of decoding between the state register and the
    // event register.
    dtbp_step u_step (
        .cur       (state_reg),
        .blob_byte (blob.blob_byte),
        .nxt       (state_next),
        .ev_valid  (ev_valid),
        .ev        (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_HEADER;
            state_reg.byte_pos      <= '0;
            state_reg.word_shift    <= '0;
            state_reg.struct_start  <= '0;
            state_reg.strings_start <= '0;
            state_reg.token_off     <= '0;
            state_reg.prop_len      <= '0;
            state_reg.skip_rem      <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Event register with skid entry; an event is pushed only for
    // bytes that complete a token or a header check.
    dtbp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire && ev_valid),
        .push_data (ev),
        .space     (space),
        .events    (events)
    );

    // Once finished, the parser never leaves the done phase.
    done_is_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_DONE) |=> (state_reg.phase == PH_DONE))
        else $error("parser left the done phase");

    // The header phase only covers the first sixteen bytes.
    header_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_HEADER) |-> (state_reg.byte_pos < 32'd16))
        else $error("header phase past header bytes");

    // No byte is taken while the event queue is full.
    no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!space) |=> $stable(state_reg))
        else $error("state advanced with event queue full");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// tb_top: self-checking bench for devicetree_blob_token_parser.
// Streams one blob (fixed opening tokens, then random ones) and checks each event
// against a local parser model. Needs dtbp_pkg, dtbp_in_if, dtbp_out_if and the RTL.
`timescale 1ns / 1ps

module tb_top
    import dtbp_pkg::*;
;

    // kinds of blob piece the stimulus can lay down
    typedef enum logic [2:0] {
        PART_HEADER,
        PART_BEGIN,
        PART_END_NODE,
        PART_PROP,
        PART_NOP,
        PART_TOKEN
    } blob_part_t;

    // one row of the opening sequence; arg_a/arg_b depend on the part:
    //   header: struct offset / strings offset
    //   begin:  name length (chars before the terminator)
    //   prop:   value length / nameoff
    //   token:  raw token word
    typedef struct packed {
        blob_part_t part;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
        logic        typed;
        event_t      ev;
    } opening_row_t;

    localparam int OPENING_ROWS  = 10;
    localparam int RANDOM_BYTES  = 900;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 300000;

    logic clk;
    logic rst_n;

    dtbp_in_if  blob_if ();
    dtbp_out_if event_if ();

    devicetree_blob_token_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .blob   (blob_if),
        .events (event_if)
    );

    // ---------------------------------------------------------------
    // Parser model state: mirrors the block's walk over the blob.
    // ---------------------------------------------------------------
    phase_t      fdt_phase;
    logic [31:0] fdt_pos;
    logic [31:0] fdt_shift;
    logic [31:0] fdt_struct;
    logic [31:0] fdt_strings;
    logic [31:0] fdt_tok;
    logic [31:0] fdt_plen;
    logic [31:0] fdt_skip;

    event_t awaited_events[$];   // events the block still owes us, oldest first
    int     error_count = 0;
    int     blob_len    = 0;     // bytes accepted so far (= next blob offset)
    int     cycle_count = 0;

    // idling knobs, percent per cycle
    int     tx_idle_pct  = 0;
    int     rx_stall_pct = 0;
    bit     hold_req     = 0;

    // when set, events raised by the current row take row_event instead of
    // the model's answer (hand-written values for the opening rows)
    bit     row_typed = 0;
    event_t row_event;

    // Advance the model by one blob byte. got=1 when the byte completes a token or a header check.
    task automatic parse_blob_byte(input logic [7:0] b, output bit got, output event_t ev);
        logic [31:0] pos;
        logic [31:0] rel;
        got = 1'b0;
        ev  = '0;
        if (fdt_phase == PH_DONE)
            return;
        pos     = fdt_pos;
        fdt_pos = pos + 32'd1;

        // waiting for the structure block, or skipping pad up to a word boundary
        if (fdt_phase == PH_WAIT) begin
            if (pos != fdt_struct)
                return;
            fdt_phase = PH_TOKEN;
            fdt_tok   = pos;
        end else if (fdt_phase == PH_ALIGN) begin
            if (pos[1:0] != 2'b00)
                return;
            fdt_phase = PH_TOKEN;
            fdt_tok   = pos;
        end

        fdt_shift = {fdt_shift[23:0], b};

        case (fdt_phase)
            PH_HEADER: begin
                if (pos == HDR_MAGIC_LAST && fdt_shift != FDT_MAGIC) begin
                    ev.kind   = EV_BAD_HEADER;
                    got       = 1'b1;
                    fdt_phase = PH_DONE;
                end else begin
                    if (pos == HDR_STRUCT_LAST) begin
                        fdt_struct = fdt_shift;
                        if (fdt_struct < MIN_STRUCT_OFF) begin
                            ev.kind   = EV_BAD_HEADER;
                            got       = 1'b1;
                            fdt_phase = PH_DONE;
                        end
                    end
                    if (pos == HDR_STRINGS_LAST) begin
                        fdt_strings = fdt_shift;
                        fdt_phase   = PH_WAIT;
                    end
                end
            end
            PH_TOKEN: begin
                rel = pos - fdt_tok;
                if (rel == REL_TOKEN_LAST) begin
                    ev.token_offset = fdt_tok;
                    ev.token_value  = fdt_shift;
                    got             = 1'b1;
                    case (fdt_shift)
                        TOK_BEGIN_NODE: begin
                            ev.kind        = EV_BEGIN_NODE;
                            ev.name_offset = fdt_tok + WORD_BYTES;
                            fdt_phase      = PH_NAME;
                        end
                        TOK_END_NODE: begin
                            ev.kind   = EV_END_NODE;
                            fdt_phase = PH_ALIGN;
                        end
                        TOK_PROP: begin
                            // event comes once length and nameoff are in
                            got       = 1'b0;
                            fdt_phase = PH_PROPHEAD;
                        end
                        TOK_NOP: begin
                            ev.kind   = EV_NOP;
                            fdt_phase = PH_ALIGN;
                        end
                        TOK_END: begin
                            ev.kind   = EV_END;
                            fdt_phase = PH_DONE;
                        end
                        default: begin
                            ev.kind   = EV_BAD_TOKEN;
                            fdt_phase = PH_DONE;
                        end
                    endcase
                end
            end
            PH_NAME: begin
                if (b == 8'd0)
                    fdt_phase = PH_ALIGN;
            end
            PH_PROPHEAD: begin
                rel = pos - fdt_tok;
                if (rel == REL_LENGTH_LAST) begin
                    fdt_plen = fdt_shift;
                end else if (rel == REL_NAMEOFF_LAST) begin
                    ev.kind         = EV_PROP;
                    ev.token_offset = fdt_tok;
                    ev.name_offset  = fdt_strings + fdt_shift;   // wraps mod 2^32
                    ev.data_offset  = pos + 32'd1;
                    ev.data_length  = fdt_plen;
                    ev.token_value  = TOK_PROP;
                    got             = 1'b1;
                    fdt_skip        = fdt_plen;
                    fdt_phase       = (fdt_plen == 32'd0) ? PH_ALIGN : PH_DATA;
                end
            end
            PH_DATA: begin
                fdt_skip = fdt_skip - 32'd1;
                if (fdt_skip == 32'd0)
                    fdt_phase = PH_ALIGN;
            end
            default: begin
                fdt_phase = PH_DONE;
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Byte source. Valid stays up across back-to-back transactions; an
    // idle gap is drawn before each byte from tx_idle_pct.
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        bit     got;
        event_t ev;
        while ($urandom_range(99) < tx_idle_pct) begin
            blob_if.valid <= 1'b0;
            @(posedge clk);
        end
        blob_if.valid     <= 1'b1;
        blob_if.blob_byte <= b;
        @(posedge clk);
        while (!blob_if.ready)
            @(posedge clk);
        // transaction taken at this edge
        blob_len++;
        parse_blob_byte(b, got, ev);
        if (got)
            awaited_events.push_back(row_typed ? row_event : ev);
    endtask

    // big-endian, as in the blob
    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_byte(w[8*i +: 8]);
    endtask

    // pad bytes up to the next multiple of 4 from blob start; contents are junk
    task automatic send_pad();
        while (blob_len[1:0] != 2'b00)
            send_byte(8'($urandom));
    endtask

    task automatic send_part(input blob_part_t part, input logic [31:0] arg_a,
                             input logic [31:0] arg_b);
        case (part)
            PART_HEADER: begin
                send_word(FDT_MAGIC);
                send_word($urandom);            // totalsize, never checked
                send_word(arg_a);
                send_word(arg_b);
                // rest of the header up to the structure block: junk
                while (blob_len < int'(arg_a))
                    send_byte(8'($urandom));
            end
            PART_BEGIN: begin
                send_word(TOK_BEGIN_NODE);
                repeat (arg_a)
                    send_byte(8'($urandom_range(1, 255)));
                send_byte(8'd0);
                send_pad();
            end
            PART_END_NODE: send_word(TOK_END_NODE);
            PART_PROP: begin
                send_word(TOK_PROP);
                send_word(arg_a);
                send_word(arg_b);
                repeat (arg_a)
                    send_byte(8'($urandom));
                send_pad();
            end
            PART_NOP:   send_word(TOK_NOP);
            PART_TOKEN: send_word(arg_a);
            default: ;
        endcase
    endtask

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            error_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // Clock, reset, input defaults
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n             = 1'b0;
        blob_if.valid     = 1'b0;
        blob_if.blob_byte = 8'd0;
        event_if.ready    = 1'b0;
    end

    // watchdog
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Event sink. Ready is redrawn every cycle from rx_stall_pct; a hold
    // request holds it low until its countdown runs out, so the event buffer
    // fills and the byte input has to back off.
    // ---------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                event_if.ready <= 1'b0;
            end else begin
                event_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Event checker: every accepted event against the oldest expectation.
    initial
    begin
        event_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && event_if.valid && event_if.ready) begin
                if (awaited_events.size() == 0) begin
                    $error("event kind %0d at offset %0h with nothing awaited",
                           event_if.event_kind, event_if.token_offset);
                    error_count++;
                end else begin
                    want = awaited_events.pop_front();
                    compare_field("event_kind", 32'(want.kind), 32'(event_if.event_kind));
                    compare_field("token_offset", want.token_offset, event_if.token_offset);
                    compare_field("name_offset", want.name_offset, event_if.name_offset);
                    compare_field("data_offset", want.data_offset, event_if.data_offset);
                    compare_field("data_length", want.data_length, event_if.data_length);
                    compare_field("token_value", want.token_value, event_if.token_value);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus: one blob for the whole run. Reset is applied once, and
    // the parser goes dead after its end or a bad token, so the blob is
    // well formed throughout and only its last token decides how it ends.
    // ---------------------------------------------------------------
    initial
    begin
        opening_row_t opening_rows [0:OPENING_ROWS-1];
        logic [31:0]  last_word;
        int           pick;
        bit           hold_done;

        // Opening rows. Structure block sits at the smallest legal offset (40),
        // strings near the top of the address space so nameoff sums wrap.
        opening_rows = '{
            '{PART_HEADER,   32'd40, 32'hFFFF_FFF0, 1'b0, '0},
            // empty node name: terminator right after the token
            '{PART_BEGIN,    32'd0,  32'd0,         1'b1,
              '{EV_BEGIN_NODE, 32'd40, 32'd44, 32'd0, 32'd0, TOK_BEGIN_NODE}},
            // zero-length property, strings + 0x10 wraps to 0
            '{PART_PROP,     32'd0,  32'h0000_0010, 1'b1,
              '{EV_PROP, 32'd48, 32'd0, 32'd60, 32'd0, TOK_PROP}},
            '{PART_NOP,      32'd0,  32'd0,         1'b1,
              '{EV_NOP, 32'd60, 32'd0, 32'd0, 32'd0, TOK_NOP}},
            // nameoff all ones, value needs padding
            '{PART_PROP,     32'd5,  32'hFFFF_FFFF, 1'b1,
              '{EV_PROP, 32'd64, 32'hFFFF_FFEF, 32'd76, 32'd5, TOK_PROP}},
            // name ends one byte short of a word boundary
            '{PART_BEGIN,    32'd3,  32'd0,         1'b1,
              '{EV_BEGIN_NODE, 32'd84, 32'd88, 32'd0, 32'd0, TOK_BEGIN_NODE}},
            '{PART_END_NODE, 32'd0,  32'd0,         1'b1,
              '{EV_END_NODE, 32'd92, 32'd0, 32'd0, 32'd0, TOK_END_NODE}},
            // nameoff 0 lands on the strings base; value fills whole words
            '{PART_PROP,     32'd8,  32'd0,         1'b1,
              '{EV_PROP, 32'd96, 32'hFFFF_FFF0, 32'd108, 32'd8, TOK_PROP}},
            '{PART_BEGIN,    32'd7,  32'd0,         1'b0, '0},
            '{PART_END_NODE, 32'd0,  32'd0,         1'b0, '0}
        };

        fdt_phase   = PH_HEADER;
        fdt_pos     = '0;
        fdt_shift   = '0;
        fdt_struct  = '0;
        fdt_strings = '0;
        fdt_tok     = '0;
        fdt_plen    = '0;
        fdt_skip    = '0;
        hold_done   = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening sequence, no idling
        for (int r = 0; r < OPENING_ROWS; r++) begin
            row_typed = opening_rows[r].typed;
            row_event = opening_rows[r].ev;
            send_part(opening_rows[r].part, opening_rows[r].arg_a, opening_rows[r].arg_b);
        end
        row_typed = 1'b0;

        // random tokens; idling phases keyed off the blob offset
        while (blob_len < RANDOM_BYTES) begin
            if (blob_len < 400) begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
                // long sink hold while bytes keep coming
                if (blob_len >= 250 && !hold_done) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
            end else if (blob_len < 550) begin
                tx_idle_pct  = 67;
                rx_stall_pct = 0;
            end else if (blob_len < 700) begin
                tx_idle_pct  = 0;
                rx_stall_pct = 67;
            end else begin
                tx_idle_pct  = 17;
                rx_stall_pct = 17;
            end

            pick = $urandom_range(99);
            if (pick < 25)
                send_part(PART_BEGIN, $urandom_range(0, 11), 32'd0);
            else if (pick < 45)
                send_part(PART_END_NODE, 32'd0, 32'd0);
            else if (pick < 80)
                send_part(PART_PROP,
                          ($urandom_range(9) == 0) ? $urandom_range(13, 64)
                                                   : $urandom_range(0, 12),
                          $urandom);
            else
                send_part(PART_NOP, 32'd0, 32'd0);
        end

        // closing token: proper end or an unknown word, then trailing junk
        // that the parser must swallow without a word
        if ($urandom_range(1) == 0) begin
            last_word = TOK_END;
        end else begin
            do
                last_word = $urandom;
            while (last_word inside {TOK_BEGIN_NODE, TOK_END_NODE, TOK_PROP,
                                     TOK_NOP, TOK_END});
        end
        send_part(PART_TOKEN, last_word, 32'd0);
        repeat (16)
            send_byte(8'($urandom));
        blob_if.valid <= 1'b0;

        // drain
        while (awaited_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
hdl/dtbp_pkg.sv
hdl/dtbp_in_if.sv
hdl/dtbp_out_if.sv
hdl/dtbp_step.sv
hdl/dtbp_out_reg.sv
hdl/devicetree_blob_token_parser.sv
tb/tb_top.sv
